// ===== design/ssf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants of the scanline span fill unit.
// ----------------------------------------------------------------------------
package ssf_pkg;

  // Edge coordinate width (signed Q16.4)
  localparam int unsigned CW = 20;
  // Crossing x width (signed, 8 fraction bits)
  localparam int unsigned XW = 26;
  // Quotient bits produced by the crossing divider
  localparam int unsigned QW = 25;
  // Default edge store depth
  localparam int unsigned MAX_EDGES_DEF = 32;
  // Most spans reported per row
  localparam int unsigned MAX_RES = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_ROW   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_WINDING = 2'd0,
    REG_COLOR   = 2'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_MULT,
    ST_DIV,
    ST_INSERT,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // One crossing held in a sort cell; dir 1 means +1, 0 means -1
  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic                 dir;
  } xing_t;

  // Control broadcast to the cell chain
  typedef struct packed {
    logic clr;  // empty every cell
    logic ins;  // insert the new crossing
    logic shl;  // move all cells one place toward the head
  } chain_ctl_t;

endpackage
`default_nettype wire

// ===== design/ssf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_cell
// One insertion sort cell: holds a crossing, takes its left neighbor's
// crossing when a smaller one is inserted ahead of it, and shifts toward the
// head during readout.
// ----------------------------------------------------------------------------
module ssf_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssf_pkg::chain_ctl_t ctl_i,
  input  wire ssf_pkg::xing_t     new_i,    // crossing being inserted
  input  wire ssf_pkg::xing_t     left_i,   // neighbor toward the head
  input  wire logic               left_gt_i,
  input  wire ssf_pkg::xing_t     right_i,  // neighbor toward the tail
  output ssf_pkg::xing_t          cell_o,
  output logic                    gt_o
);

  ssf_pkg::xing_t cell_d, cell_q;

  // This cell holds a crossing strictly greater than the new one
  assign gt_o   = cell_q.valid && (cell_q.x > new_i.x);
  assign cell_o = cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctl_i.clr) begin
      cell_d.valid = 1'b0;
    end else if (ctl_i.shl) begin
      cell_d = right_i;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        cell_d = left_i;
      end else if (left_i.valid && (gt_o || !cell_q.valid)) begin
        cell_d = new_i;
        cell_d.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
      cell_q.x     <= '0;
      cell_q.dir   <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/scanline_polygon_span_fill_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit
// Edge store plus row rasterizer: crossings of the sample line are found by
// a multiply and a serial divide, sorted in a chain of insertion cells and
// turned into spans by the even-odd or nonzero rule.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  command | start_i, busy_o, action_i, coords,    | in
//          | row_index_i                           |
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i,| in
//          | cfg_data_i                            |
//  result  | out_valid_o + span fields             | out
//
// Clear and add complete without raising busy_o. A row holds busy_o high until
// its spans are found; its last result shows in the same cycle as busy_o falls.
// Each crossing passes through a 25 step serial divider. A command transfers
// when start_i is high and busy_o low. Each result is shown for one cycle with
// out_valid_o; the receiver cannot stall. Reset clears edge count, overflow
// flag, config and sort chain, not the edge store.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_unit #(
  parameter int unsigned MAX_EDGES = ssf_pkg::MAX_EDGES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic signed [ssf_pkg::CW-1:0] start_x_i,
  input  wire logic signed [ssf_pkg::CW-1:0] start_y_i,
  input  wire logic signed [ssf_pkg::CW-1:0] end_x_i,
  input  wire logic signed [ssf_pkg::CW-1:0] end_y_i,
  input  wire logic signed [15:0]         row_index_i,
  // configuration
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [31:0]                cfg_data_i,
  // results
  output logic                            out_valid_o,
  output logic signed [15:0]              out_row_o,
  output logic signed [15:0]              span_left_o,
  output logic signed [15:0]              span_right_o,
  output logic                            span_valid_o,
  output logic [31:0]                     span_color_o,
  output logic                            edge_overflow_o,
  output logic                            last_o
);

  localparam int unsigned CW   = ssf_pkg::CW;
  localparam int unsigned XW   = ssf_pkg::XW;
  localparam int unsigned QW   = ssf_pkg::QW;
  localparam int unsigned AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned WW   = NW + 1;
  localparam int unsigned SW   = $clog2(ssf_pkg::MAX_RES + 1);
  localparam int unsigned DW   = CW + 1;       // difference width
  localparam int unsigned PW   = 2 * DW;       // product width
  localparam logic signed [XW:0] PIX_MIN = -(XW+1)'(32768);
  localparam logic signed [XW:0] PIX_MAX = (XW+1)'(32767);

  // ---------------- configuration ----------------
  logic        winding_q;
  logic [31:0] color_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      winding_q <= 1'b0;
      color_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssf_pkg::REG_WINDING: winding_q <= cfg_data_i[0];
        ssf_pkg::REG_COLOR:   color_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- control registers ----------------
  ssf_pkg::state_e state_d, state_q;
  logic [NW-1:0]   count_d, count_q;
  logic            ovf_d, ovf_q;
  logic [NW-1:0]   idx_d, idx_q;
  logic [NW-1:0]   nc_d, nc_q;
  logic [NW-1:0]   drn_d, drn_q;
  logic [4:0]      step_d, step_q;
  logic [SW-1:0]   nspan_d, nspan_q;
  logic            pend_v_d, pend_v_q;
  logic            half_d, half_q;
  logic signed [WW-1:0] wind_d, wind_q;
  logic            ov_d, ov_q, ol_d, ol_q;

  // payload registers
  logic signed [15:0]   row_d, row_q;
  logic signed [CW-1:0] scan_d, scan_q;
  logic [DW-1:0]        a_d, a_q, b_d, b_q, dv_d, dv_q;
  logic                 neg_d, neg_q, dir_d, dir_q;
  logic signed [CW-1:0] sx_d, sx_q;
  logic [DW-1:0]        rem_d, rem_q;
  logic [QW-1:0]        nsh_d, nsh_q;
  logic signed [XW-1:0] lx_d, lx_q;
  logic signed [15:0]   pl_d, pl_q, pr_d, pr_q;
  logic signed [15:0]   oleft_d, oleft_q, oright_d, oright_q, orow_d, orow_q;
  logic [31:0]          ocol_d, ocol_q;

  // ---------------- edge store ----------------
  logic [4*CW-1:0] mem_q [MAX_EDGES];
  logic [4*CW-1:0] rd_q;
  logic            mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AW-1:0]] <= {start_x_i, start_y_i, end_x_i, end_y_i};
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  logic signed [CW-1:0] e_sx, e_sy, e_ex, e_ey;
  assign {e_sx, e_sy, e_ex, e_ey} = rd_q;

  // ---------------- sort chain ----------------
  ssf_pkg::chain_ctl_t ctl;
  ssf_pkg::xing_t      new_x;
  ssf_pkg::xing_t      cells [MAX_EDGES];
  logic                gts   [MAX_EDGES];
  ssf_pkg::xing_t      head_fill, tail_fill;

  assign head_fill = '{valid: 1'b1, x: '0, dir: 1'b0};
  assign tail_fill = '{valid: 1'b0, x: '0, dir: 1'b0};

  for (genvar gi = 0; gi < MAX_EDGES; gi++) begin : g_cell
    ssf_pkg::xing_t lft, rgt;
    logic           lgt;
    if (gi == 0) begin : g_head
      assign lft = head_fill;
      assign lgt = 1'b0;
    end else begin : g_mid
      assign lft = cells[gi-1];
      assign lgt = gts[gi-1];
    end
    if (gi == MAX_EDGES - 1) begin : g_tail
      assign rgt = tail_fill;
    end else begin : g_body
      assign rgt = cells[gi+1];
    end
    ssf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .new_i     (new_x),
      .left_i    (lft),
      .left_gt_i (lgt),
      .right_i   (rgt),
      .cell_o    (cells[gi]),
      .gt_o      (gts[gi])
    );
  end

  // ---------------- datapath helpers ----------------
  logic signed [DW-1:0] d_sy, d_sx, d_y;
  logic                 crosses;
  logic [PW-1:0]        prod;
  logic [DW:0]          trial;
  logic                 trial_ge;
  logic [XW-1:0]        q_mag;
  logic signed [XW-1:0] q_s, x_new;
  logic signed [WW-1:0] wind_nx;

  assign d_sy = DW'(scan_q) - DW'(e_sy);
  assign d_sx = DW'(e_ex) - DW'(e_sx);
  assign d_y  = DW'(e_ey) - DW'(e_sy);
  assign crosses = ((e_sy <= scan_q) && (e_ey > scan_q)) ||
                   ((e_ey <= scan_q) && (e_sy > scan_q));
  assign prod  = PW'(a_q) * PW'(b_q);
  assign trial = {rem_q, nsh_q[QW-1]};
  assign trial_ge = trial >= {1'b0, dv_q};
  assign q_mag = XW'(nsh_q) + XW'(neg_q && (rem_q != '0));
  assign q_s   = neg_q ? -$signed(q_mag) : $signed(q_mag);
  assign x_new = {{(XW-CW-4){sx_q[CW-1]}}, sx_q, 4'b0000} + q_s;

  // Span candidate from the crossing at the chain head
  ssf_pkg::xing_t       head;
  logic                 span_hit;
  logic signed [XW-1:0] sl8, sr8;
  logic signed [XW:0]   lsum, lpix, rpix, lclamp, rclamp;
  logic                 span_ok;

  assign head    = cells[0];
  assign wind_nx = head.dir ? wind_q + WW'(1) : wind_q - WW'(1);
  assign lsum    = {sl8[XW-1], sl8} + (XW+1)'(255);
  assign lpix    = lsum >>> 8;
  assign rpix    = $signed({sr8[XW-1], sr8}) >>> 8;
  assign span_ok = !(rpix < lpix) && !(rpix < PIX_MIN) && !(lpix > PIX_MAX) &&
                   (nspan_q < SW'(ssf_pkg::MAX_RES));
  assign lclamp  = (lpix < PIX_MIN) ? PIX_MIN : lpix;
  assign rclamp  = (rpix > PIX_MAX) ? PIX_MAX : rpix;

  always_comb begin
    span_hit = 1'b0;
    sl8 = lx_q;
    sr8 = head.x;
    if (winding_q) begin
      span_hit = half_q;
    end else begin
      span_hit = (wind_q != '0) && (wind_nx == '0);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    idx_d    = idx_q;
    nc_d     = nc_q;
    drn_d    = drn_q;
    step_d   = step_q;
    nspan_d  = nspan_q;
    pend_v_d = pend_v_q;
    half_d   = half_q;
    wind_d   = wind_q;
    ov_d     = 1'b0;
    ol_d     = 1'b0;
    row_d    = row_q;
    scan_d   = scan_q;
    a_d      = a_q;
    b_d      = b_q;
    dv_d     = dv_q;
    neg_d    = neg_q;
    dir_d    = dir_q;
    sx_d     = sx_q;
    rem_d    = rem_q;
    nsh_d    = nsh_q;
    lx_d     = lx_q;
    pl_d     = pl_q;
    pr_d     = pr_q;
    oleft_d  = oleft_q;
    oright_d = oright_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    mem_we   = 1'b0;
    ctl      = '0;
    new_x    = '{valid: 1'b1, x: x_new, dir: dir_q};

    unique case (state_q)
      ssf_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            ssf_pkg::ACT_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            ssf_pkg::ACT_ADD: begin
              if (count_q < NW'(MAX_EDGES)) begin
                mem_we  = 1'b1;
                count_d = count_q + NW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ssf_pkg::ACT_ROW: begin
              row_d    = row_index_i;
              scan_d   = {row_index_i, 4'b1000};
              idx_d    = '0;
              nc_d     = '0;
              drn_d    = '0;
              nspan_d  = '0;
              pend_v_d = 1'b0;
              half_d   = 1'b0;
              wind_d   = '0;
              ctl.clr  = 1'b1;
              state_d  = (count_q == '0) ? ssf_pkg::ST_DRAIN : ssf_pkg::ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ssf_pkg::ST_FETCH: begin
        state_d = ssf_pkg::ST_CHECK;
      end
      ssf_pkg::ST_CHECK: begin
        a_d   = d_sy[DW-1] ? DW'(-d_sy) : DW'(d_sy);
        b_d   = d_sx[DW-1] ? DW'(-d_sx) : DW'(d_sx);
        dv_d  = d_y[DW-1]  ? DW'(-d_y)  : DW'(d_y);
        neg_d = d_sy[DW-1] ^ d_sx[DW-1] ^ d_y[DW-1];
        dir_d = (e_ey > e_sy);
        sx_d  = e_sx;
        if (crosses) begin
          state_d = ssf_pkg::ST_MULT;
        end else begin
          idx_d   = idx_q + NW'(1);
          state_d = (idx_d == count_q) ? ssf_pkg::ST_DRAIN : ssf_pkg::ST_FETCH;
        end
      end
      ssf_pkg::ST_MULT: begin
        // numerator = product * 16, split into first remainder and shift bits
        rem_d   = prod[PW-1:PW-DW];
        nsh_d   = {prod[PW-DW-1:0], 4'b0000};
        step_d  = '0;
        state_d = ssf_pkg::ST_DIV;
      end
      ssf_pkg::ST_DIV: begin
        rem_d  = trial_ge ? DW'(trial - {1'b0, dv_q}) : trial[DW-1:0];
        nsh_d  = {nsh_q[QW-2:0], trial_ge};
        step_d = step_q + 5'd1;
        if (step_q == 5'(QW - 1)) begin
          state_d = ssf_pkg::ST_INSERT;
        end
      end
      ssf_pkg::ST_INSERT: begin
        ctl.ins = 1'b1;
        nc_d    = nc_q + NW'(1);
        idx_d   = idx_q + NW'(1);
        state_d = (idx_d == count_q) ? ssf_pkg::ST_DRAIN : ssf_pkg::ST_FETCH;
      end
      ssf_pkg::ST_DRAIN: begin
        if (drn_q == nc_q) begin
          state_d = ssf_pkg::ST_FINISH;
        end else begin
          ctl.shl = 1'b1;
          drn_d   = drn_q + NW'(1);
          if (winding_q) begin
            half_d = !half_q;
            lx_d   = head.x;
          end else begin
            wind_d = wind_nx;
            if (wind_q == '0) begin
              lx_d = head.x;
            end
          end
          if (span_hit && span_ok) begin
            // show the held span, hold the new one until the next span or the row end
            if (pend_v_q) begin
              ov_d     = 1'b1;
              orow_d   = row_q;
              oleft_d  = pl_q;
              oright_d = pr_q;
              ocol_d   = color_q;
            end
            pend_v_d = 1'b1;
            pl_d     = lclamp[15:0];
            pr_d     = rclamp[15:0];
            nspan_d  = nspan_q + SW'(1);
          end
        end
      end
      ssf_pkg::ST_FINISH: begin
        ov_d    = 1'b1;
        ol_d    = 1'b1;
        orow_d  = row_q;
        oleft_d = pend_v_q ? pl_q : '0;
        oright_d = pend_v_q ? pr_q : '0;
        ocol_d  = pend_v_q ? color_q : '0;
        state_d = ssf_pkg::ST_IDLE;
      end
      default: state_d = ssf_pkg::ST_IDLE;
    endcase
  end

  // span_valid of the shown result: zero only for the empty row marker
  logic osv_d, osv_q;
  assign osv_d = (state_q == ssf_pkg::ST_FINISH) ? pend_v_q : 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssf_pkg::ST_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      idx_q    <= '0;
      nc_q     <= '0;
      drn_q    <= '0;
      step_q   <= '0;
      nspan_q  <= '0;
      pend_v_q <= 1'b0;
      half_q   <= 1'b0;
      wind_q   <= '0;
      ov_q     <= 1'b0;
      ol_q     <= 1'b0;
      osv_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      idx_q    <= idx_d;
      nc_q     <= nc_d;
      drn_q    <= drn_d;
      step_q   <= step_d;
      nspan_q  <= nspan_d;
      pend_v_q <= pend_v_d;
      half_q   <= half_d;
      wind_q   <= wind_d;
      ov_q     <= ov_d;
      ol_q     <= ol_d;
      osv_q    <= osv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    scan_q   <= scan_d;
    a_q      <= a_d;
    b_q      <= b_d;
    dv_q     <= dv_d;
    neg_q    <= neg_d;
    dir_q    <= dir_d;
    sx_q     <= sx_d;
    rem_q    <= rem_d;
    nsh_q    <= nsh_d;
    lx_q     <= lx_d;
    pl_q     <= pl_d;
    pr_q     <= pr_d;
    oleft_q  <= oleft_d;
    oright_q <= oright_d;
    orow_q   <= orow_d;
    ocol_q   <= ocol_d;
  end

  // ---------------- outputs ----------------
  assign busy_o          = (state_q != ssf_pkg::ST_IDLE);
  assign out_valid_o     = ov_q;
  assign out_row_o       = orow_q;
  assign span_left_o     = oleft_q;
  assign span_right_o    = oright_q;
  assign span_valid_o    = osv_q;
  assign span_color_o    = ocol_q;
  assign edge_overflow_o = ovf_q;
  assign last_o          = ol_q;

endmodule
`default_nettype wire

// ===== tb/sv/scanline_polygon_span_fill_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit_tb
// Self-checking bench: edge commands and row requests go to the unit with
// random gaps. A span predictor tracks the edge store and the config, and
// every span strobe is checked against the oldest predicted span.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_unit_tb;

  typedef logic signed [ssf_pkg::CW-1:0] coord_t;

  typedef struct {
    logic signed [15:0] row;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               valid;
    logic [31:0]        color;
    logic               ovf;
    logic               last;
  } span_t;

  // action code outside the defined set
  localparam logic [1:0] ACT_RSVD = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           action_i = ssf_pkg::ACT_CLEAR;
  coord_t               start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [15:0]   row_index_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = ssf_pkg::REG_WINDING;
  logic [31:0]          cfg_data_i = '0;
  logic                 out_valid_o;
  logic signed [15:0]   out_row_o, span_left_o, span_right_o;
  logic                 span_valid_o;
  logic [31:0]          span_color_o;
  logic                 edge_overflow_o, last_o;

  localparam int WDOG_LIMIT = 20000;

  // predictor copy of the block
  longint edge_sx[ssf_pkg::MAX_EDGES_DEF], edge_sy[ssf_pkg::MAX_EDGES_DEF];
  longint edge_ex[ssf_pkg::MAX_EDGES_DEF], edge_ey[ssf_pkg::MAX_EDGES_DEF];
  int     n_edges;
  bit     ovf_flag;
  bit     mode_even_odd;
  logic [31:0] color_reg;

  span_t  span_q[$];
  int     n_errors = 0;
  int     n_rows = 0;
  int     n_spans = 0;
  int     n_cmds = 0;
  bit     burst_mode = 0;
  int     idle_cnt = 0;

  scanline_polygon_span_fill_unit DUT (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, WDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  // append one span unless the row is full, the span is empty or off the 16-bit range
  function automatic void push_span(longint row, longint l8, longint r8, ref int cnt);
    longint lft, rgt;
    span_t  s;
    lft = -floor_div(-l8, 256);
    rgt = floor_div(r8, 256);
    if (cnt >= ssf_pkg::MAX_RES || rgt < lft || rgt < -32768 || lft > 32767) return;
    if (lft < -32768) lft = -32768;
    if (rgt > 32767) rgt = 32767;
    s.row = 16'(row); s.left = 16'(lft); s.right = 16'(rgt); s.valid = 1'b1;
    s.color = color_reg; s.ovf = ovf_flag; s.last = 1'b0;
    span_q.push_back(s);
    cnt++;
  endfunction

  // spans of one row from the current edge set
  function automatic void predict_row(longint row);
    longint scan, num, cx[ssf_pkg::MAX_EDGES_DEF], tx;
    int     cd[ssf_pkg::MAX_EDGES_DEF], td, nc, cnt, j, wind, prev;
    longint spos;
    span_t  s;
    scan = row * 16 + 8;
    nc = 0; cnt = 0; wind = 0; spos = 0;
    for (int i = 0; i < n_edges; i++) begin
      if ((edge_sy[i] <= scan && edge_ey[i] > scan) ||
          (edge_ey[i] <= scan && edge_sy[i] > scan)) begin
        num = (scan - edge_sy[i]) * (edge_ex[i] - edge_sx[i]) * 16;
        cx[nc] = edge_sx[i] * 16 + floor_div(num, edge_ey[i] - edge_sy[i]);
        cd[nc] = (edge_ey[i] > edge_sy[i]) ? 1 : -1;
        nc++;
      end
    end
    // stable insertion sort by x
    for (int i = 1; i < nc; i++) begin
      tx = cx[i]; td = cd[i]; j = i;
      while (j > 0 && cx[j-1] > tx) begin
        cx[j] = cx[j-1]; cd[j] = cd[j-1]; j--;
      end
      cx[j] = tx; cd[j] = td;
    end
    if (mode_even_odd) begin
      for (int i = 0; i + 1 < nc; i += 2) push_span(row, cx[i], cx[i+1], cnt);
    end else begin
      for (int i = 0; i < nc; i++) begin
        prev = wind;
        wind += cd[i];
        if (prev == 0 && wind != 0) spos = cx[i];
        else if (prev != 0 && wind == 0) push_span(row, spos, cx[i], cnt);
      end
    end
    if (cnt == 0) begin
      s.row = 16'(row); s.left = '0; s.right = '0; s.valid = 1'b0;
      s.color = '0; s.ovf = ovf_flag; s.last = 1'b1;
      span_q.push_back(s);
    end else begin
      span_q[span_q.size()-1].last = 1'b1;
    end
    n_rows++;
  endfunction

  function automatic void predict_cmd(logic [1:0] act, coord_t sx, coord_t sy,
                                      coord_t ex, coord_t ey, logic signed [15:0] row);
    case (act)
      ssf_pkg::ACT_CLEAR: begin
        n_edges = 0; ovf_flag = 0;
      end
      ssf_pkg::ACT_ADD: begin
        if (n_edges < ssf_pkg::MAX_EDGES_DEF) begin
          edge_sx[n_edges] = longint'(sx); edge_sy[n_edges] = longint'(sy);
          edge_ex[n_edges] = longint'(ex); edge_ey[n_edges] = longint'(ey);
          n_edges++;
        end else begin
          ovf_flag = 1;
        end
      end
      ssf_pkg::ACT_ROW: predict_row(longint'(row));
      default: ;
    endcase
  endfunction

  // result checker
  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : p_check
    span_t s;
    if (rst_ni && out_valid_o) begin
      if (span_q.size() == 0) begin
        $display("%0t unexpected span: expected none actual row %0d", $time, out_row_o);
        n_errors++;
      end else begin
        s = span_q.pop_front();
        chk("out_row", s.row, out_row_o);
        chk("span_left", s.left, span_left_o);
        chk("span_right", s.right, span_right_o);
        chk("span_valid", s.valid, span_valid_o);
        chk("span_color", s.color, span_color_o);
        chk("edge_overflow", s.ovf, edge_overflow_o);
        chk("last", s.last, last_o);
        if (s.valid) n_spans++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // one command transfer; start stays high after it
  task automatic send_cmd(logic [1:0] act, coord_t sx, coord_t sy,
                          coord_t ex, coord_t ey, logic signed [15:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    start_x_i <= sx; start_y_i <= sy; end_x_i <= ex; end_y_i <= ey;
    row_index_i <= row;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_cmd(act, sx, sy, ex, ey, row);
    n_cmds++;
  endtask

  task automatic add_edge(int sx, int sy, int ex, int ey);
    send_cmd(ssf_pkg::ACT_ADD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
             16'($urandom));
  endtask

  task automatic do_row(int row);
    send_cmd(ssf_pkg::ACT_ROW, coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), 16'(row));
  endtask

  task automatic do_clear();
    send_cmd(ssf_pkg::ACT_CLEAR, coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), 16'($urandom));
  endtask

  // wait until all spans arrived and the unit has gone quiet
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (span_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_reg(ssf_pkg::reg_e idx, logic [31:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == ssf_pkg::REG_WINDING) mode_even_odd = val[0];
    else color_reg = val;
  endtask

  // square, row inside and outside, horizontal edges, unused code
  task automatic test_basic();
    do_clear();
    add_edge(16, 16, 16, 160);
    add_edge(16, 160, 160, 160);
    add_edge(160, 160, 160, 16);
    add_edge(160, 16, 16, 16);
    do_row(4);
    do_row(0);
    do_row(10);
    send_cmd(ACT_RSVD, -20'sd524288, 20'sd524287, 20'sd524287, -20'sd524288, -16'sd32768);
    do_row(1);
    do_row(-32768);
    do_row(32767);
  endtask

  // equal x, odd leftover, empty span, range edge, overlapping windings
  task automatic test_special();
    do_clear();
    add_edge(100, 0, 100, 64);
    add_edge(100, 64, 100, 0);
    add_edge(103, 0, 103, 64);
    add_edge(200, 0, 40, 64);
    add_edge(50, 0, 50, 64);
    do_row(1);
    do_row(2);
    do_clear();
    add_edge(524287, -524288, 524287, 524287);
    add_edge(-524288, 524287, -524288, -524288);
    add_edge(524280, 0, 524280, 32);
    do_row(0);
    do_row(-32768);
  endtask

  // store capacity and sticky flag
  task automatic test_overflow();
    do_clear();
    for (int i = 0; i < ssf_pkg::MAX_EDGES_DEF + 2; i++)
      add_edge(i * 40, 0, i * 40 + 8, 64);
    do_row(1);
    do_clear();
    do_row(1);
  endtask

  task automatic rand_edge(int bx, int by);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      add_edge($urandom, $urandom, $urandom, $urandom);
    else if (r == 1)
      add_edge(bx + $urandom_range(0, 640), by + 160, bx + $urandom_range(0, 640), by + 160);
    else
      add_edge(bx + $urandom_range(0, 640), by + $urandom_range(0, 320),
               bx + $urandom_range(0, 640), by + $urandom_range(0, 320));
  endtask

  // random polygons in a local window with rows over them
  task automatic test_random(int n_items);
    int bx, by, ne, nr, sent, r;
    sent = 0;
    while (sent < n_items) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (span_q.size() != 0) @(posedge clk_i);
      end
      bx = $signed($urandom_range(0, 8000)) - 4000;
      by = $signed($urandom_range(0, 8000)) - 4000;
      do_clear();
      ne = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
      for (int i = 0; i < ne; i++) rand_edge(bx, by);
      nr = $urandom_range(1, 6);
      for (int i = 0; i < nr; i++) begin
        if ($urandom_range(0, 9) == 0) do_row($urandom);
        else do_row((by >>> 4) + $signed($urandom_range(0, 22)) - 1);
      end
      if ($urandom_range(0, 9) == 0)
        send_cmd(ACT_RSVD, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), 16'($urandom));
      sent += 1 + ne + nr;
    end
    burst_mode = 0;
  endtask

  initial begin
    n_edges = 0; ovf_flag = 0; mode_even_odd = 0; color_reg = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic();
    set_reg(ssf_pkg::REG_WINDING, 32'd1);
    set_reg(ssf_pkg::REG_COLOR, 32'hFFFF_FFFF);
    test_basic();
    test_special();
    set_reg(ssf_pkg::REG_WINDING, 32'd0);
    test_special();
    test_overflow();
    set_reg(ssf_pkg::REG_COLOR, $urandom);
    test_random(70);
    set_reg(ssf_pkg::REG_WINDING, 32'hFFFF_FFFE);
    set_reg(ssf_pkg::REG_COLOR, 32'h0000_0000);
    test_random(70);
    set_reg(ssf_pkg::REG_WINDING, 32'd1);
    set_reg(ssf_pkg::REG_COLOR, $urandom);
    test_random(70);

    wait_drained();
    $display("Covered %0d commands, %0d rows, %0d real spans; both winding rules,",
             n_cmds, n_rows, n_spans);
    $display("edge store overflow, clipping at the coordinate range and random polygons.");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
